// ===== rtl/vri_pkg.sv =====
`default_nettype none

package vri_pkg;

  localparam int COORD_BITS = 16;
  localparam int TRIG_W     = 16;
  localparam int HALF_W     = 15;
  localparam int OUT_W      = 19;
  localparam int TRIG_SHIFT = 14;
  localparam int IDX_W      = 3;
  localparam int DATA_W     = 16;

  // centred coordinate, then growth per rotation (each can scale by up to four)
  localparam int CTR_W      = ((COORD_BITS > HALF_W) ? COORD_BITS : HALF_W) + 1;
  localparam int R1_W       = CTR_W + 3;
  localparam int R2_W       = R1_W + 2;
  localparam int R3_W       = R2_W + 2;
  localparam int ROT_IN_W   = R2_W;
  localparam int ROT_OUT_W  = R3_W;
  localparam int PROD_W     = ROT_IN_W + TRIG_W;
  localparam int SUM_W      = PROD_W + 1;

  // isometric projection
  localparam int COS30_Q16  = 56756;
  localparam int COS_W      = 17;
  localparam int COS_SHIFT  = 16;
  localparam int D_W        = R3_W + 1;
  localparam int S_W        = R3_W + 2;
  localparam int PX_W       = D_W + COS_W;

  localparam int OUT_MIN    = -(2 ** (OUT_W - 1));
  localparam int OUT_MAX    = (2 ** (OUT_W - 1)) - 1;

  localparam int NSTG       = 10;

  localparam logic [IDX_W-1:0] REG_SIN_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COS_X  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SIN_Y  = 3'd2;
  localparam logic [IDX_W-1:0] REG_COS_Y  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SIN_Z  = 3'd4;
  localparam logic [IDX_W-1:0] REG_COS_Z  = 3'd5;
  localparam logic [IDX_W-1:0] REG_HALF_W = 3'd6;
  localparam logic [IDX_W-1:0] REG_HALF_H = 3'd7;

  localparam logic [TRIG_W-1:0] TRIG_ONE  = 16'd16384;

  typedef struct packed {
    logic [TRIG_W-1:0] sin_x;
    logic [TRIG_W-1:0] cos_x;
    logic [TRIG_W-1:0] sin_y;
    logic [TRIG_W-1:0] cos_y;
    logic [TRIG_W-1:0] sin_z;
    logic [TRIG_W-1:0] cos_z;
    logic [HALF_W-1:0] half_w;
    logic [HALF_W-1:0] half_h;
  } vri_cfg_t;

  typedef struct packed {
    logic mul;
    logic sum;
  } vri_rot_en_t;

  typedef struct packed {
    logic sum;
    logic mul;
    logic fin;
  } vri_prj_en_t;

endpackage

`default_nettype wire

// ===== rtl/vertex_rotate_iso_project_core.sv =====
// Map vertex to isometric screen point.
// Input channel: map_x, map_y, map_height with in_valid / in_stall; a transfer
// happens on a rising edge with in_valid high and in_stall low.
// Output channel: screen_x, screen_y with out_valid / out_stall, same rule.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Indices 0..5 are the Q2.14 sine/cosine words for the x, y
// and z rotations, 6 and 7 the centring half width and half height. Write
// them only while no vertex is in flight.
// The pipeline has 10 register stages: centring, two per rotation (multiply,
// then sum and truncate), and three for the projection (difference/sum,
// cos30 multiply, truncate and clamp). Throughput is one vertex per cycle
// while the receiver does not stall; each stage holds only while its
// successor is full and held, so empty stages are filled even when the
// receiver stalls, and nothing is dropped or repeated.
// Synchronous reset empties the pipeline and restores identity rotation with
// zero centring.
`default_nettype none

module vertex_rotate_iso_project_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [vri_pkg::COORD_BITS-1:0] map_x,
  input  wire logic signed [vri_pkg::COORD_BITS-1:0] map_y,
  input  wire logic signed [vri_pkg::COORD_BITS-1:0] map_height,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [vri_pkg::OUT_W-1:0]           screen_x,
  output logic signed [vri_pkg::OUT_W-1:0]           screen_y,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [vri_pkg::IDX_W-1:0]             cfg_index,
  input  wire logic [vri_pkg::DATA_W-1:0]            cfg_data
);
  import vri_pkg::*;

  vri_cfg_t regs;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  logic [NSTG-1:0] vld_src;

  logic signed [CTR_W-1:0]     x0;
  logic signed [CTR_W-1:0]     y0;
  logic signed [CTR_W-1:0]     z0;
  logic signed [CTR_W-1:0]     x0_s1;
  logic signed [CTR_W-1:0]     x0_s2;
  logic signed [ROT_OUT_W-1:0] rx_p;
  logic signed [ROT_OUT_W-1:0] rx_q;
  logic signed [ROT_OUT_W-1:0] ry_p;
  logic signed [ROT_OUT_W-1:0] ry_q;
  logic signed [ROT_OUT_W-1:0] rz_p;
  logic signed [ROT_OUT_W-1:0] rz_q;
  logic signed [R1_W-1:0]      y1_s3;
  logic signed [R1_W-1:0]      y1_s4;
  logic signed [R2_W-1:0]      z2_s5;
  logic signed [R2_W-1:0]      z2_s6;

  vri_rot_en_t rx_en;
  vri_rot_en_t ry_en;
  vri_rot_en_t rz_en;
  vri_prj_en_t pj_en;

  vri_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // a stage may load when it is empty or its successor moves on
  always_comb begin
    adv[NSTG-1] = ~vld[NSTG-1] | ~out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  assign vld_src   = {vld[NSTG-2:0], in_valid};
  assign in_stall  = ~adv[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  // centring
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x0 <= CTR_W'(map_x) - CTR_W'(regs.half_w);
      y0 <= CTR_W'(map_y) - CTR_W'(regs.half_h);
      z0 <= CTR_W'(map_height);
    end
  end

  // side values that skip a rotation
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      x0_s1 <= x0;
    end
    if (adv[2]) begin
      x0_s2 <= x0_s1;
    end
    if (adv[3]) begin
      y1_s3 <= rx_p[R1_W-1:0];
    end
    if (adv[4]) begin
      y1_s4 <= y1_s3;
    end
    if (adv[5]) begin
      z2_s5 <= ry_q[R2_W-1:0];
    end
    if (adv[6]) begin
      z2_s6 <= z2_s5;
    end
  end

  assign rx_en = '{mul: adv[1], sum: adv[2]};
  assign ry_en = '{mul: adv[3], sum: adv[4]};
  assign rz_en = '{mul: adv[5], sum: adv[6]};
  assign pj_en = '{sum: adv[7], mul: adv[8], fin: adv[9]};

  // about x: p = y1, q = z1
  vri_rotate u_rot_x (
    .clk (clk),
    .en  (rx_en),
    .a   (ROT_IN_W'(y0)),
    .b   (ROT_IN_W'(z0)),
    .c   ($signed(regs.cos_x)),
    .s   ($signed(regs.sin_x)),
    .p   (rx_p),
    .q   (rx_q)
  );

  // about y: p = x2, q = z2
  vri_rotate u_rot_y (
    .clk (clk),
    .en  (ry_en),
    .a   (ROT_IN_W'(x0_s2)),
    .b   (ROT_IN_W'($signed(rx_q[R1_W-1:0]))),
    .c   ($signed(regs.cos_y)),
    .s   ($signed(regs.sin_y)),
    .p   (ry_p),
    .q   (ry_q)
  );

  // about z: p = y3, q = x3
  vri_rotate u_rot_z (
    .clk (clk),
    .en  (rz_en),
    .a   (ROT_IN_W'(y1_s4)),
    .b   (ROT_IN_W'($signed(ry_p[R2_W-1:0]))),
    .c   ($signed(regs.cos_z)),
    .s   ($signed(regs.sin_z)),
    .p   (rz_p),
    .q   (rz_q)
  );

  vri_project u_proj (
    .clk      (clk),
    .en       (pj_en),
    .x3       (rz_q[R3_W-1:0]),
    .y3       (rz_p[R3_W-1:0]),
    .z2       (z2_s6),
    .screen_x (screen_x),
    .screen_y (screen_y)
  );

endmodule

`default_nettype wire

// ===== rtl/vri_cfg.sv =====
`default_nettype none

module vri_cfg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [vri_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [vri_pkg::DATA_W-1:0] cfg_data,
  output vri_pkg::vri_cfg_t           regs
);
  import vri_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sin_x  <= '0;
      regs.cos_x  <= TRIG_ONE;
      regs.sin_y  <= '0;
      regs.cos_y  <= TRIG_ONE;
      regs.sin_z  <= '0;
      regs.cos_z  <= TRIG_ONE;
      regs.half_w <= '0;
      regs.half_h <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIN_X:  regs.sin_x  <= cfg_data[TRIG_W-1:0];
        REG_COS_X:  regs.cos_x  <= cfg_data[TRIG_W-1:0];
        REG_SIN_Y:  regs.sin_y  <= cfg_data[TRIG_W-1:0];
        REG_COS_Y:  regs.cos_y  <= cfg_data[TRIG_W-1:0];
        REG_SIN_Z:  regs.sin_z  <= cfg_data[TRIG_W-1:0];
        REG_COS_Z:  regs.cos_z  <= cfg_data[TRIG_W-1:0];
        REG_HALF_W: regs.half_w <= cfg_data[HALF_W-1:0];
        REG_HALF_H: regs.half_h <= cfg_data[HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vri_rotate.sv =====
`default_nettype none

// p = trunc((a*c + b*s) / 2^14), q = trunc((b*c - a*s) / 2^14)
module vri_rotate (
  input  wire logic                                clk,
  input  wire vri_pkg::vri_rot_en_t                en,
  input  wire logic signed [vri_pkg::ROT_IN_W-1:0] a,
  input  wire logic signed [vri_pkg::ROT_IN_W-1:0] b,
  input  wire logic signed [vri_pkg::TRIG_W-1:0]   c,
  input  wire logic signed [vri_pkg::TRIG_W-1:0]   s,
  output logic signed [vri_pkg::ROT_OUT_W-1:0]     p,
  output logic signed [vri_pkg::ROT_OUT_W-1:0]     q
);
  import vri_pkg::*;

  localparam logic signed [SUM_W-1:0] RND = SUM_W'((2 ** TRIG_SHIFT) - 1);

  logic signed [PROD_W-1:0] ac;
  logic signed [PROD_W-1:0] bs;
  logic signed [PROD_W-1:0] bc;
  logic signed [PROD_W-1:0] as_p;
  logic signed [SUM_W-1:0]  p_sum;
  logic signed [SUM_W-1:0]  q_sum;
  logic signed [SUM_W-1:0]  p_adj;
  logic signed [SUM_W-1:0]  q_adj;
  logic signed [SUM_W-1:0]  p_shf;
  logic signed [SUM_W-1:0]  q_shf;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      ac   <= PROD_W'(a) * PROD_W'(c);
      bs   <= PROD_W'(b) * PROD_W'(s);
      bc   <= PROD_W'(b) * PROD_W'(c);
      as_p <= PROD_W'(a) * PROD_W'(s);
    end
  end

  // exact sum first, then one truncation toward zero
  always_comb begin
    p_sum = SUM_W'(ac) + SUM_W'(bs);
    q_sum = SUM_W'(bc) - SUM_W'(as_p);
    p_adj = p_sum[SUM_W-1] ? (p_sum + RND) : p_sum;
    q_adj = q_sum[SUM_W-1] ? (q_sum + RND) : q_sum;
    p_shf = p_adj >>> TRIG_SHIFT;
    q_shf = q_adj >>> TRIG_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      p <= p_shf[ROT_OUT_W-1:0];
      q <= q_shf[ROT_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vri_project.sv =====
`default_nettype none

module vri_project (
  input  wire logic                            clk,
  input  wire vri_pkg::vri_prj_en_t            en,
  input  wire logic signed [vri_pkg::R3_W-1:0] x3,
  input  wire logic signed [vri_pkg::R3_W-1:0] y3,
  input  wire logic signed [vri_pkg::R2_W-1:0] z2,
  output logic signed [vri_pkg::OUT_W-1:0]     screen_x,
  output logic signed [vri_pkg::OUT_W-1:0]     screen_y
);
  import vri_pkg::*;

  localparam logic signed [COS_W-1:0] COS30 = COS_W'(COS30_Q16);
  localparam logic signed [PX_W-1:0]  PX_RND = PX_W'((2 ** COS_SHIFT) - 1);
  localparam logic signed [PX_W-1:0]  PX_LO = PX_W'(OUT_MIN);
  localparam logic signed [PX_W-1:0]  PX_HI = PX_W'(OUT_MAX);
  localparam logic signed [S_W-1:0]   S_ONE = S_W'(1);
  localparam logic signed [S_W-1:0]   SY_LO = S_W'(OUT_MIN);
  localparam logic signed [S_W-1:0]   SY_HI = S_W'(OUT_MAX);
  localparam logic signed [OUT_W-1:0] Q_LO  = OUT_W'(OUT_MIN);
  localparam logic signed [OUT_W-1:0] Q_HI  = OUT_W'(OUT_MAX);

  logic signed [D_W-1:0]   d;
  logic signed [S_W-1:0]   sm;
  logic signed [PX_W-1:0]  prod;
  logic signed [OUT_W-1:0] sy_sat;
  logic signed [S_W-1:0]   sm_adj;
  logic signed [S_W-1:0]   sm_half;
  logic signed [OUT_W-1:0] sy_next;
  logic signed [PX_W-1:0]  prod_adj;
  logic signed [PX_W-1:0]  px;
  logic signed [OUT_W-1:0] sx_next;

  always_ff @(posedge clk) begin
    if (en.sum) begin
      d  <= D_W'(x3) - D_W'(y3);
      sm <= S_W'(x3) + S_W'(y3) - (S_W'(z2) <<< 1);
    end
  end

  // halve toward zero and clamp the vertical coordinate
  always_comb begin
    sm_adj  = sm[S_W-1] ? (sm + S_ONE) : sm;
    sm_half = sm_adj >>> 1;
    if (sm_half < SY_LO) begin
      sy_next = Q_LO;
    end else if (sm_half > SY_HI) begin
      sy_next = Q_HI;
    end else begin
      sy_next = sm_half[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod   <= PX_W'(d) * PX_W'(COS30);
      sy_sat <= sy_next;
    end
  end

  always_comb begin
    prod_adj = prod[PX_W-1] ? (prod + PX_RND) : prod;
    px       = prod_adj >>> COS_SHIFT;
    if (px < PX_LO) begin
      sx_next = Q_LO;
    end else if (px > PX_HI) begin
      sx_next = Q_HI;
    end else begin
      sx_next = px[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.fin) begin
      screen_x <= sx_next;
      screen_y <= sy_sat;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_vertex_rotate_iso_project_core.sv =====
module tb_vertex_rotate_iso_project_core;
  import vri_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
  } screen_pt_t;

  typedef struct {
    int phase;
    int x;
    int y;
    int h;
    bit typed;
    int ex;
    int ey;
  } vertex_row_t;

  localparam int N_ROWS       = 24;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 64;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  wire                           in_stall;
  logic signed [COORD_BITS-1:0]  map_x;
  logic signed [COORD_BITS-1:0]  map_y;
  logic signed [COORD_BITS-1:0]  map_height;
  wire                           out_valid;
  logic                          out_stall;
  wire signed [OUT_W-1:0]        screen_x;
  wire signed [OUT_W-1:0]        screen_y;
  logic                          cfg_valid;
  wire                           cfg_ready;
  logic [IDX_W-1:0]              cfg_index;
  logic [DATA_W-1:0]             cfg_data;

  vri_cfg_t   cfg_now;
  vri_cfg_t   dir_cfg [3];
  screen_pt_t pending_points [$];
  int         mismatch_count = 0;
  int         no_gap_left = 0;
  bit         force_hold = 1'b0;

  // phase 0 runs on the reset setting, so its results can be typed in directly
  vertex_row_t dir_rows [N_ROWS] = '{
    '{0,      0,      0,      0, 1'b1,      0,      0},
    '{0,    100,    100,      0, 1'b1,      0,    100},
    '{0,      0,      0,    100, 1'b1,      0,   -100},
    '{0,  32767, -32768,      0, 1'b1,  56755,      0},
    '{0, -32768,  32767,      0, 1'b1, -56755,      0},
    '{0, -32768, -32768,  32767, 1'b1,      0, -65535},
    '{0,  32767,  32767, -32768, 1'b1,      0,  65535},
    '{0,      1,      0,      0, 1'b1,      0,      0},
    '{0,     -1,      0,      0, 1'b1,      0,      0},
    '{0,      0,      0,     -1, 1'b1,      0,      1},
    '{0,      2,      0,      0, 1'b1,      1,      1},
    '{0,     -2,      0,      0, 1'b1,     -1,     -1},
    '{1,  32767,  32767,  32767, 1'b0,      0,      0},
    '{1, -32768, -32768, -32768, 1'b0,      0,      0},
    '{1,  32767, -32768,  32767, 1'b0,      0,      0},
    '{1, -32768,  32767, -32768, 1'b0,      0,      0},
    '{1,      0,      0,      0, 1'b0,      0,      0},
    '{1,  12345,  -2345,    777, 1'b0,      0,      0},
    '{2,      0,      0,      0, 1'b0,      0,      0},
    '{2,  32767, -32768, -32768, 1'b0,      0,      0},
    '{2, -32768,  32767,  32767, 1'b0,      0,      0},
    '{2,     -1,     -1,      1, 1'b0,      0,      0},
    '{2,      1,      1,     -1, 1'b0,      0,      0},
    '{2, -32768, -32768, -32768, 1'b0,      0,      0}
  };

  vertex_rotate_iso_project_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .map_x      (map_x),
    .map_y      (map_y),
    .map_height (map_height),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clamp_out(input longint v);
    if (v < OUT_MIN) return OUT_MIN;
    if (v > OUT_MAX) return OUT_MAX;
    return v;
  endfunction

  // centre, rotate about x then y then z, then isometric projection
  function automatic screen_pt_t project_vertex(input vri_cfg_t c,
                                                input logic signed [COORD_BITS-1:0] mx,
                                                input logic signed [COORD_BITS-1:0] my,
                                                input logic signed [COORD_BITS-1:0] mh);
    longint unit, sxv, cxv, syv, cyv, szv, czv;
    longint x0, y0, z0, y1, z1, x2, z2, x3, y3, px, py;
    screen_pt_t pt;
    unit = longint'(1) << TRIG_SHIFT;
    sxv = longint'($signed(c.sin_x));
    cxv = longint'($signed(c.cos_x));
    syv = longint'($signed(c.sin_y));
    cyv = longint'($signed(c.cos_y));
    szv = longint'($signed(c.sin_z));
    czv = longint'($signed(c.cos_z));
    x0 = longint'(mx) - longint'(c.half_w);
    y0 = longint'(my) - longint'(c.half_h);
    z0 = longint'(mh);
    y1 = (y0 * cxv + z0 * sxv) / unit;
    z1 = (z0 * cxv - y0 * sxv) / unit;
    x2 = (x0 * cyv + z1 * syv) / unit;
    z2 = (z1 * cyv - x0 * syv) / unit;
    x3 = (x2 * czv - y1 * szv) / unit;
    y3 = (x2 * szv + y1 * czv) / unit;
    px = ((x3 - y3) * longint'(COS30_Q16)) / (longint'(1) << COS_SHIFT);
    py = ((x3 + y3) - 2 * z2) / 2;
    pt.sx = OUT_W'(clamp_out(px));
    pt.sy = OUT_W'(clamp_out(py));
    return pt;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) no_gap_left = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return COORD_BITS'($urandom);
    if (r < 85) return COORD_BITS'($urandom_range(0, 600) - 300);
    case ($urandom_range(0, 3))
      0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
      1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [TRIG_W-1:0] extreme_trig();
    case ($urandom_range(0, 4))
      0:       return TRIG_ONE;
      1:       return -TRIG_ONE;
      2:       return '0;
      3:       return 16'h7FFF;
      default: return 16'h8000;
    endcase
  endfunction

  function automatic logic [HALF_W-1:0] rand_half();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return HALF_W'($urandom);
    endcase
  endfunction

  // kind 0 identity, 1 within the unit range, 2 any word, 3 extremes only
  function automatic vri_cfg_t random_angles(input int kind);
    logic [TRIG_W-1:0] w [6];
    vri_cfg_t c;
    for (int i = 0; i < 6; i++) begin
      case (kind)
        0:       w[i] = (i % 2) ? TRIG_ONE : '0;
        1:       w[i] = TRIG_W'($urandom_range(0, 32768) - 16384);
        2:       w[i] = TRIG_W'($urandom);
        default: w[i] = extreme_trig();
      endcase
    end
    c.sin_x  = w[0];
    c.cos_x  = w[1];
    c.sin_y  = w[2];
    c.cos_y  = w[3];
    c.sin_z  = w[4];
    c.cos_z  = w[5];
    c.half_w = rand_half();
    c.half_h = rand_half();
    return c;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SIN_X:  cfg_now.sin_x  = data;
      REG_COS_X:  cfg_now.cos_x  = data;
      REG_SIN_Y:  cfg_now.sin_y  = data;
      REG_COS_Y:  cfg_now.cos_y  = data;
      REG_SIN_Z:  cfg_now.sin_z  = data;
      REG_COS_Z:  cfg_now.cos_z  = data;
      REG_HALF_W: cfg_now.half_w = data[HALF_W-1:0];
      REG_HALF_H: cfg_now.half_h = data[HALF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // top bit of the half extents is unused, so it carries junk
  task automatic load_angles(input vri_cfg_t c, input bit junk);
    write_reg(REG_SIN_X, c.sin_x);
    write_reg(REG_COS_X, c.cos_x);
    write_reg(REG_SIN_Y, c.sin_y);
    write_reg(REG_COS_Y, c.cos_y);
    write_reg(REG_SIN_Z, c.sin_z);
    write_reg(REG_COS_Z, c.cos_z);
    write_reg(REG_HALF_W, {junk, c.half_w});
    write_reg(REG_HALF_H, {~junk, c.half_h});
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (NSTG + 2) @(negedge clk);
  endtask

  task automatic send_vertex(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic signed [COORD_BITS-1:0] h,
                             input bit typed, input int ex, input int ey);
    int gap;
    screen_pt_t pt;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    map_x      = x;
    map_y      = y;
    map_height = h;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      pt.sx = OUT_W'(ex);
      pt.sy = OUT_W'(ey);
    end else begin
      pt = project_vertex(cfg_now, x, y, h);
    end
    pending_points.push_back(pt);
    @(negedge clk);
  endtask

  // receiver: free stretches, choppy stretches and the odd long hold
  initial begin
    int run;
    int mode;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (force_hold) begin
        force_hold = 1'b0;
        mode = 2;
        run  = HOLD_CYCLES;
      end else begin
        mode = $urandom_range(0, 99);
        if (mode < 55) begin
          mode = 0;
          run  = $urandom_range(5, 40);
        end else if (mode < 93) begin
          mode = 1;
          run  = $urandom_range(10, 40);
        end else begin
          mode = 2;
          run  = $urandom_range(20, 60);
        end
      end
      repeat (run) begin
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 2) == 0);
          default: out_stall = 1'b1;
        endcase
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    screen_pt_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected screen point, actual x=%0d y=%0d",
                 $time, screen_x, screen_y);
        mismatch_count++;
      end else begin
        want = pending_points.pop_front();
        if (screen_x !== want.sx) begin
          $display("%0t: screen_x mismatch, expected %0d actual %0d",
                   $time, want.sx, screen_x);
          mismatch_count++;
        end
        if (screen_y !== want.sy) begin
          $display("%0t: screen_y mismatch, expected %0d actual %0d",
                   $time, want.sy, screen_y);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int cur_phase;
    rst        = 1'b1;
    in_valid   = 1'b0;
    map_x      = '0;
    map_y      = '0;
    map_height = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;

    cfg_now.sin_x  = '0;
    cfg_now.cos_x  = TRIG_ONE;
    cfg_now.sin_y  = '0;
    cfg_now.cos_y  = TRIG_ONE;
    cfg_now.sin_z  = '0;
    cfg_now.cos_z  = TRIG_ONE;
    cfg_now.half_w = '0;
    cfg_now.half_h = '0;
    dir_cfg[0] = cfg_now;

    // oversized trig words scale the vertex far enough to clamp
    dir_cfg[1].sin_x  = 16'h8000;
    dir_cfg[1].cos_x  = 16'h8000;
    dir_cfg[1].sin_y  = 16'h7FFF;
    dir_cfg[1].cos_y  = 16'h8000;
    dir_cfg[1].sin_z  = 16'h8000;
    dir_cfg[1].cos_z  = 16'h7FFF;
    dir_cfg[1].half_w = '1;
    dir_cfg[1].half_h = '0;

    // a quarter turn about y, scaled diagonal turns about x and z, with full centring on y
    dir_cfg[2].sin_x  = -TRIG_ONE;
    dir_cfg[2].cos_x  = TRIG_ONE;
    dir_cfg[2].sin_y  = TRIG_ONE;
    dir_cfg[2].cos_y  = '0;
    dir_cfg[2].sin_z  = -TRIG_ONE;
    dir_cfg[2].cos_z  = -TRIG_ONE;
    dir_cfg[2].half_w = '0;
    dir_cfg[2].half_h = '1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    cur_phase = 0;
    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].phase != cur_phase) begin
        wait_idle();
        cur_phase = dir_rows[i].phase;
        load_angles(dir_cfg[cur_phase], 1'b0);
      end
      send_vertex(COORD_BITS'(dir_rows[i].x), COORD_BITS'(dir_rows[i].y),
                  COORD_BITS'(dir_rows[i].h), dir_rows[i].typed,
                  dir_rows[i].ex, dir_rows[i].ey);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      load_angles(random_angles(p % 4), 1'($urandom_range(0, 1)));
      // long receiver hold while vertices keep coming, to back the pipe up
      if (p == 0) force_hold = 1'b1;
      for (int j = 0; j < PHASE_ITEMS; j++)
        send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, 0, 0);
    end
    wait_idle();

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vri_pkg.sv
rtl/vri_cfg.sv
rtl/vri_rotate.sv
rtl/vri_project.sv
rtl/vertex_rotate_iso_project_core.sv
tb/sv/tb_vertex_rotate_iso_project_core.sv
